FILE: hw/rtl/piau_pkg.sv
// Package for the padded integer to ASCII unit.
// Holds sizes, radix and character codes, controller states and the
// command/status structs shared by controller and datapath. No dependencies.
`timescale 1ns / 1ps

package piau_pkg;

  localparam int MAX_CHARS  = 64;
  localparam int ADDR_W     = $clog2(MAX_CHARS);
  localparam int CNT_W      = $clog2(MAX_CHARS + 1);
  localparam int NUM_W      = 64;
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int CHAR_W     = 8;
  localparam int FW_W       = 7;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    RADIX_BIN  = 2'd0,
    RADIX_DEC  = 2'd1,
    RADIX_HEX  = 2'd2,
    RADIX_NONE = 2'd3
  } radix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_EXTRACT,
    ST_SIGN,
    ST_SETUP,
    ST_PAD,
    ST_TEXT
  } state_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic extract;
    logic sign;
    logic setup;
    logic pad;
    logic text;
  } cmd_t;

  typedef struct packed {
    logic   in_zero;
    radix_t in_radix;
    logic   dabble_done;
    logic   extract_done;
    logic   pad_nz;
    logic   cnt_nz;
    logic   load_ok;
    logic   pad_last;
    logic   ptr_last;
    logic   ptr_nz;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-4){1'b0}}, d};
    return (d > 4'd9) ? (CH_A + dx - 8'd10) : (CH_ZERO + dx);
  endfunction

endpackage

FILE: hw/rtl/piau_in_if.sv
// Input channel of the padded integer to ASCII unit: valid/ready plus the
// value and format fields. Depends on piau_pkg for widths.
`timescale 1ns / 1ps

interface piau_in_if import piau_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] number_in;
  logic [1:0]              radix_sel;
  logic [FW_W-1:0]         field_width;
  logic                    zero_pad;

  modport source (output valid, number_in, radix_sel, field_width, zero_pad,
                  input ready);
  modport sink (input valid, number_in, radix_sel, field_width, zero_pad,
                output ready);
endinterface

FILE: hw/rtl/piau_out_if.sv
// Result channel of the padded integer to ASCII unit: valid/ready plus one
// character and its last flag. Depends on piau_pkg for widths.
`timescale 1ns / 1ps

interface piau_out_if import piau_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink (input valid, out_char, last_char, output ready);
endinterface

FILE: hw/rtl/padded_integer_to_ascii_unit.sv
// Padded integer to ASCII unit, top level: controller, datapath and the
// 64-entry digit store. Uses piau_pkg, piau_in_if, piau_out_if, piau_ram,
// piau_ctrl and piau_dp.
//
// One value at a time: it is taken in, decimal values then pass through a
// bit-serial binary-to-BCD converter, binary, decimal and hexadecimal
// values write their digits into the digit store and pass a sign state,
// every value passes a setup state, and then one character leaves per
// cycle while the sink is ready (pad characters, then the text read back
// from the store, which reads one entry ahead). A zero value skips straight
// to setup. A new value is taken as soon as the last character of the
// previous one sits in the output register.
`timescale 1ns / 1ps

module padded_integer_to_ascii_unit import piau_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  piau_in_if.sink    in_ch,
  piau_out_if.source out_ch
);

  cmd_t              cmd;
  status_t           status;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  piau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  piau_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .number_in   (in_ch.number_in),
    .radix_sel   (in_ch.radix_sel),
    .field_width (in_ch.field_width),
    .zero_pad    (in_ch.zero_pad),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_char    (out_ch.out_char),
    .last_char   (out_ch.last_char),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  piau_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_CHARS)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: hw/rtl/piau_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module piau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/piau_ctrl.sv
// Controller FSM of the padded integer to ASCII unit: sequences load,
// BCD conversion, digit extraction, sign, padding and text. Uses piau_pkg.
`timescale 1ns / 1ps

module piau_ctrl import piau_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.in_zero) begin
            state_nxt = ST_SETUP;
          end else begin
            case (status.in_radix)
              RADIX_DEC:            state_nxt = ST_DABBLE;
              RADIX_BIN, RADIX_HEX: state_nxt = ST_EXTRACT;
              default:              state_nxt = ST_SETUP;
            endcase
          end
        end
      end
      ST_DABBLE: begin
        cmd.dabble = 1'b1;
        if (status.dabble_done) begin
          state_nxt = ST_EXTRACT;
        end
      end
      ST_EXTRACT: begin
        cmd.extract = 1'b1;
        if (status.extract_done) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        cmd.sign  = 1'b1;
        state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (status.pad_nz) begin
          state_nxt = ST_PAD;
        end else if (status.cnt_nz) begin
          state_nxt = ST_TEXT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd.pad = 1'b1;
        if (status.load_ok && status.pad_last) begin
          state_nxt = status.ptr_nz ? ST_TEXT : ST_IDLE;
        end
      end
      ST_TEXT: begin
        cmd.text = 1'b1;
        if (status.load_ok && status.ptr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/piau_dp.sv
// Datapath of the padded integer to ASCII unit: magnitude, shift-add-3
// BCD converter, digit extractor, counters, output register and digit store
// ports. Uses piau_pkg; the digit store is a piau_ram in the top level.
`timescale 1ns / 1ps

module piau_dp import piau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output status_t                 status,
  input  logic signed [NUM_W-1:0] number_in,
  input  logic [1:0]              radix_sel,
  input  logic [FW_W-1:0]         field_width,
  input  logic                    zero_pad,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHAR_W-1:0]       out_char,
  output logic                    last_char,
  output logic                    ram_we,
  output logic [ADDR_W-1:0]       ram_waddr,
  output logic [CHAR_W-1:0]       ram_wdata,
  output logic [ADDR_W-1:0]       ram_raddr,
  input  logic [CHAR_W-1:0]       ram_rdata
);

  logic [NUM_W-1:0]  mag_r;
  logic [BCD_W-1:0]  bcd_r;
  radix_t            radix_r;
  logic              neg_r;
  logic [FW_W-1:0]   width_r;
  logic              zpad_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  pad_r;
  logic [CNT_W-1:0]  ptr_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic [NUM_W-1:0]  num_u;
  logic [NUM_W-1:0]  mag_in;
  logic [FW_W-1:0]   width_sat;
  logic [BCD_W-1:0]  bcd_adj;
  logic [3:0]        ext_digit;
  logic [BCD_W-1:0]  ext_shift;
  logic              sign_wr;
  logic              load_ok;
  logic              emit;

  always_comb begin
    num_u     = number_in;
    mag_in    = num_u[NUM_W-1] ? (~num_u + {{(NUM_W-1){1'b0}}, 1'b1}) : num_u;
    width_sat = (field_width > FW_W'(MAX_CHARS)) ? FW_W'(MAX_CHARS) : field_width;

    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] > 4'd4) ? (bcd_r[4*i +: 4] + 4'd3)
                                                   : bcd_r[4*i +: 4];
    end

    ext_digit = (radix_r == RADIX_BIN) ? {3'b000, bcd_r[0]} : bcd_r[3:0];
    ext_shift = (radix_r == RADIX_BIN) ? (bcd_r >> 1) : (bcd_r >> 4);

    sign_wr = cmd.sign && neg_r && (radix_r == RADIX_DEC) &&
              (cnt_r < CNT_W'(MAX_CHARS));
    load_ok = !out_valid_r || out_ready;
    emit    = (cmd.pad || cmd.text) && load_ok;

    ram_we    = (cmd.load && (num_u == '0)) || cmd.extract || sign_wr;
    ram_waddr = cmd.load ? '0 : cnt_r[ADDR_W-1:0];
    ram_wdata = cmd.load ? CH_ZERO : (cmd.extract ? digit_char(ext_digit) : CH_MINUS);

    if (cmd.setup) begin
      ram_raddr = cnt_r[ADDR_W-1:0] - ADDR_W'(1);
    end else if (cmd.text && load_ok) begin
      ram_raddr = ptr_r[ADDR_W-1:0] - ADDR_W'(2);
    end else begin
      ram_raddr = ptr_r[ADDR_W-1:0] - ADDR_W'(1);
    end

    status.in_zero      = (num_u == '0);
    status.in_radix     = radix_t'(radix_sel);
    status.dabble_done  = &step_r;
    status.extract_done = (ext_shift == '0) || (cnt_r == CNT_W'(MAX_CHARS - 1));
    status.pad_nz       = ({1'b0, width_r} > {1'b0, cnt_r});
    status.cnt_nz       = (cnt_r != '0);
    status.load_ok      = load_ok;
    status.pad_last     = (pad_r == CNT_W'(1));
    status.ptr_last     = (ptr_r == CNT_W'(1));
    status.ptr_nz       = (ptr_r != '0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      cnt_r       <= '0;
      pad_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        step_r <= '0;
        cnt_r  <= (num_u == '0) ? CNT_W'(1) : '0;
      end
      if (cmd.dabble) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (cmd.extract || sign_wr) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.setup) begin
        pad_r <= status.pad_nz ? (CNT_W'(width_r) - cnt_r) : '0;
        ptr_r <= cnt_r;
      end
      if (cmd.pad && load_ok) begin
        pad_r <= pad_r - CNT_W'(1);
      end
      if (cmd.text && load_ok) begin
        ptr_r <= ptr_r - CNT_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r   <= mag_in;
      bcd_r   <= (radix_sel == RADIX_DEC) ? '0 : {{(BCD_W-NUM_W){1'b0}}, mag_in};
      radix_r <= radix_t'(radix_sel);
      neg_r   <= num_u[NUM_W-1];
      width_r <= width_sat;
      zpad_r  <= zero_pad;
    end
    if (cmd.dabble) begin
      bcd_r <= {bcd_adj[BCD_W-2:0], mag_r[NUM_W-1]};
      mag_r <= {mag_r[NUM_W-2:0], 1'b0};
    end
    if (cmd.extract) begin
      bcd_r <= ext_shift;
    end
    if (cmd.pad && load_ok) begin
      out_char_r <= zpad_r ? CH_ZERO : CH_SPACE;
      out_last_r <= (pad_r == CNT_W'(1)) && (ptr_r == '0);
    end
    if (cmd.text && load_ok) begin
      out_char_r <= ram_rdata;
      out_last_r <= (ptr_r == CNT_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign last_char = out_last_r;

endmodule

FILE: hw/rtl/piau_checker.sv
// Port-level checker for the padded integer to ASCII unit, bound to the top
// level. Needs only the top level's channel signals.
`timescale 1ns / 1ps

module piau_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_char
);

  // output holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_char))
    else $error("result changed while stalled");

  // one value at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a pending non-final character means the value is still in progress
  a_no_in_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_char |-> !in_ready)
    else $error("input ready before the last character");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind padded_integer_to_ascii_unit piau_checker u_piau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .last_char (out_ch.last_char)
);
